// ----- rtl/cspmv_pkg.sv -----
package cspmv_pkg;

	// field widths
	localparam int ROW_W = 10;
	localparam int COL_W = 10;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;
	localparam int USER_W = 2;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 80;

	// wide enough for any index compare up to the largest store depth
	localparam int IDX_W = 17;

	typedef enum logic [USER_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_ENTRY = 2'd1,
		ACT_READ  = 2'd2
	} cspmv_action_t;

	typedef struct packed {
		logic capture;
		logic vec_wr;
		logic mem_rd;
		logic mul;
		logic acc_wr;
		logic out_ld;
		logic rs_zero;
		logic clr_wr;
	} cspmv_cmd_t;

	typedef struct packed {
		logic row_ok;
		logic col_ok;
		logic clr_last;
		logic out_busy;
	} cspmv_sts_t;

endpackage

// ----- rtl/cspmv_ctrl.sv -----
module cspmv_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic [cspmv_pkg::USER_W-1:0]  s_tuser,
	output logic                          s_tready,
	output cspmv_pkg::cspmv_cmd_t         cmd,
	input  cspmv_pkg::cspmv_sts_t         sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_ENT_RD,
		ST_MUL,
		ST_ACC,
		ST_RO_RD,
		ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (cspmv_pkg::cspmv_action_t'(s_tuser))
							cspmv_pkg::ACT_LOAD:  state_q <= ST_LOAD;
							cspmv_pkg::ACT_ENTRY: state_q <= ST_ENT_RD;
							cspmv_pkg::ACT_READ:  state_q <= ST_RO_RD;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOAD:   state_q <= ST_IDLE;
				ST_ENT_RD: state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_ACC;
				ST_ACC:    state_q <= ST_IDLE;
				ST_RO_RD:  state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the output register has room
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == ST_IDLE) && s_tvalid;
		cmd.clr_wr  = (state_q == ST_CLEAR);
		cmd.vec_wr  = (state_q == ST_LOAD) && sts.col_ok;
		cmd.mem_rd  = (state_q == ST_ENT_RD) || (state_q == ST_RO_RD);
		cmd.mul     = (state_q == ST_MUL);
		cmd.acc_wr  = (state_q == ST_ACC) && sts.row_ok && sts.col_ok;
		cmd.out_ld  = (state_q == ST_OUT) && !sts.out_busy;
		cmd.rs_zero = (state_q == ST_OUT) && !sts.out_busy && sts.row_ok;
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready
		&& (s_tuser == cspmv_pkg::ACT_LOAD || s_tuser == cspmv_pkg::ACT_ENTRY
		|| s_tuser == cspmv_pkg::ACT_READ) |=> !s_tready)
		else $error("accepted item did not start work");
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !cmd.capture && !cmd.acc_wr && !cmd.out_ld)
		else $error("item work during clearing pass");
`endif

endmodule

// ----- rtl/cspmv_dp.sv -----
module cspmv_dp #(
	parameter int ROWS = 1024,
	parameter int COLS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [cspmv_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cspmv_pkg::M_TDATA_W-1:0] m_tdata,
	input  cspmv_pkg::cspmv_cmd_t           cmd,
	output cspmv_pkg::cspmv_sts_t           sts
);

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int SW = cspmv_pkg::SUM_W;
	localparam int XW = cspmv_pkg::IDX_W;
	localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

	logic [cspmv_pkg::ROW_W-1:0] in_row;
	logic [cspmv_pkg::COL_W-1:0] in_col;
	logic [cspmv_pkg::VAL_W-1:0] in_val;

	assign in_row = s_tdata[cspmv_pkg::ROW_W-1:0];
	assign in_col = s_tdata[cspmv_pkg::ROW_W +: cspmv_pkg::COL_W];
	assign in_val = s_tdata[cspmv_pkg::ROW_W + cspmv_pkg::COL_W +: cspmv_pkg::VAL_W];

	// captured item
	logic [cspmv_pkg::ROW_W-1:0]        row_q;
	logic [cspmv_pkg::COL_W-1:0]        col_q;
	logic signed [cspmv_pkg::VAL_W-1:0] value_q;
	logic                               row_ok_q;
	logic                               col_ok_q;

	logic [XW-1:0] row_x;
	logic [XW-1:0] col_x;
	logic [XW-1:0] in_row_x;
	logic [XW-1:0] in_col_x;

	assign in_row_x = XW'(in_row);
	assign in_col_x = XW'(in_col);
	assign row_x    = XW'(row_q);
	assign col_x    = XW'(col_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q   <= in_row;
			col_q   <= in_col;
			value_q <= in_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= 1'b0;
			col_ok_q <= 1'b0;
		end else if (cmd.capture) begin
			row_ok_q <= (in_row_x < XW'(ROWS));
			col_ok_q <= (in_col_x < XW'(COLS));
		end
	end

	logic [RW-1:0] row_a;
	logic [CW-1:0] col_a;

	assign row_a = row_x[RW-1:0];
	assign col_a = col_x[CW-1:0];

	// clearing pass index
	logic [RW-1:0] clr_idx_q;
	logic          clr_last;

	assign clr_last = (clr_idx_q == RW'(ROWS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_wr && !clr_last) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// vector store
	logic [cspmv_pkg::VAL_W-1:0]        vec_mem [COLS];
	logic signed [cspmv_pkg::VAL_W-1:0] x_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.vec_wr) vec_mem[col_a] <= value_q;
		if (cmd.mem_rd) x_rd_q <= vec_mem[col_a];
	end

	// row sum store
	logic [SW-1:0]        rs_mem [ROWS];
	logic signed [SW-1:0] rs_rd_q;
	logic                 rs_we;
	logic [RW-1:0]        rs_wa;
	logic [SW-1:0]        rs_wd;
	logic signed [SW-1:0] sat_sum;

	assign rs_we = cmd.clr_wr || cmd.acc_wr || cmd.rs_zero;
	assign rs_wa = cmd.clr_wr ? clr_idx_q : row_a;
	assign rs_wd = cmd.acc_wr ? sat_sum : '0;

	always_ff @(posedge clk) begin
		if (rs_we) rs_mem[rs_wa] <= rs_wd;
		if (cmd.mem_rd) rs_rd_q <= rs_mem[row_a];
	end

	// exact q16.16 by q16.16 product
	logic signed [SW-1:0] prod;
	logic signed [SW-1:0] prod_q;

	assign prod = value_q * x_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= prod;
	end

	// saturating accumulate
	logic signed [SW-1:0] raw_sum;
	logic                 ovf;

	assign raw_sum = rs_rd_q + prod_q;
	assign ovf     = (rs_rd_q[SW-1] == prod_q[SW-1]) && (raw_sum[SW-1] != rs_rd_q[SW-1]);
	assign sat_sum = ovf ? (rs_rd_q[SW-1] ? SUM_MIN : SUM_MAX) : raw_sum;

	// output register
	logic                        out_valid_q;
	logic [cspmv_pkg::ROW_W-1:0] out_row_q;
	logic [SW-1:0]               out_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_row_q <= row_q;
			out_sum_q <= row_ok_q ? rs_rd_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(cspmv_pkg::M_TDATA_W - SW - cspmv_pkg::ROW_W){1'b0}},
		out_sum_q, out_row_q};

	assign sts.row_ok   = row_ok_q;
	assign sts.col_ok   = col_ok_q;
	assign sts.clr_last = clr_last;
	assign sts.out_busy = out_valid_q && !m_tready;

`ifndef SYNTHESIS
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !out_valid_q || m_tready)
		else $error("unread result overwritten");
	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_wr |-> $past(cmd.mul))
		else $error("accumulate without fresh product");
	a_clear_advances: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr && !clr_last |=> clr_idx_q == RW'($past(clr_idx_q) + 1'b1))
		else $error("clearing pass skipped a row");
`endif

endmodule

// ----- rtl/coo_sparse_matvec.sv -----
// sparse matrix-vector product over coordinate-format entries. each input word
// carries an action in s_tuser: load writes x[col] = value, entry adds the exact
// q32.32 product value * x[col] into the sum of its row (saturating at the 64-bit
// limits), and read returns that row's sum on the master side and clears it.
// loads and entries with an out-of-range index are dropped; a read of a row
// beyond ROWS still returns one word with a zero sum; action code 3 is dropped.
// one item at a time: a load passes a load state; an entry the vector and sum
// memory read, one 32x32 multiply and saturating add and write back states; a
// read a memory read state and an output state that waits for the output
// register. the sum memory has a single write port, so after reset a clearing
// pass zeroes one row per cycle, all ROWS rows, before s_tready rises.
// a finished result waits in the output register while the next item is taken.
module coo_sparse_matvec #(
	parameter int ROWS = 1024,
	parameter int COLS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// row[9:0], col[19:10], value[51:20], zero fill up to bit 55
	input  logic [cspmv_pkg::S_TDATA_W-1:0] s_tdata,
	// action[1:0]
	input  logic [cspmv_pkg::USER_W-1:0]    s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// row_out[9:0], sum[73:10], zero fill up to bit 79
	output logic [cspmv_pkg::M_TDATA_W-1:0] m_tdata
);

	// commands from the sequencer and status back from the datapath
	cspmv_pkg::cspmv_cmd_t cmd;
	cspmv_pkg::cspmv_sts_t sts;

	cspmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// vector and row sum memories, multiplier, saturating adder, output register
	cspmv_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
